/* hdl/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the Go-Back-N sender window blocks.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_SPACE    = 8;
    localparam int SEQ_BITS     = $clog2(SEQ_SPACE);
    localparam int PAYLOAD_BITS = 64;
    localparam int WSIZE_BITS   = 3;
    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(4);

    typedef logic [SEQ_BITS-1:0]     t_seq;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;
    typedef logic [WSIZE_BITS-1:0]   t_wsize;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_in_kind;

    typedef enum logic [2:0] {
        RK_SENT       = 3'd0,
        RK_REFUSED    = 3'd1,
        RK_ACK_OK     = 3'd2,
        RK_ACK_IGNORE = 3'd3,
        RK_RESENT     = 3'd4,
        RK_NO_RESEND  = 3'd5
    } t_res_kind;

    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } t_timer_cmd;

    typedef struct packed {
        t_in_kind kind;
        t_payload payload;
        t_seq     ack_number;
        logic     ack_checksum_ok;
    } t_item_in;

    typedef struct packed {
        t_res_kind  result_kind;
        t_seq       seq_num;
        t_payload   packet_data;
        t_timer_cmd timer_cmd;
        t_seq       base_after;
        logic       window_full;
        logic       last;
    } t_item_out;

    typedef struct packed {
        logic     we;
        t_seq     waddr;
        t_payload wdata;
        logic     re;
        t_seq     raddr;
    } t_mem_req;

endpackage

/* hdl/gbn_store.sv */
// ----------------------------------------------------------------------------
// gbn_store
// Packet buffer: one write and one registered read port, indexed by sequence.
// ----------------------------------------------------------------------------
module gbn_store (
    input  logic              i_clk,
    input  gbn_pkg::t_mem_req i_req,
    output gbn_pkg::t_payload o_rdata
);

    gbn_pkg::t_payload r_mem [gbn_pkg::SEQ_SPACE];
    gbn_pkg::t_payload r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/gbn_ctrl.sv */
// ----------------------------------------------------------------------------
// gbn_ctrl
// Window state, item decode, resend sequencer and result register.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gbn_pkg::t_item_in  i_item,
    input  logic               i_cfg_we,
    input  gbn_pkg::t_wsize    i_cfg_data,
    output gbn_pkg::t_mem_req  o_mem_req,
    output logic               o_strobe,
    output logic               o_from_mem,
    output gbn_pkg::t_item_out o_meta
);

    gbn_pkg::t_seq      r_base, n_base;
    gbn_pkg::t_seq      r_next, n_next;
    gbn_pkg::t_wsize    r_wsize, n_wsize;
    gbn_pkg::t_seq      r_rem, n_rem;
    gbn_pkg::t_seq      r_rseq, n_rseq;
    logic               r_strobe, n_strobe;
    logic               r_from_mem, n_from_mem;
    gbn_pkg::t_item_out r_out, n_out;

    gbn_pkg::t_seq    cnt;
    gbn_pkg::t_seq    ack_off;
    gbn_pkg::t_seq    cnt_after;
    gbn_pkg::t_mem_req mem_req;
    logic             accept;

    assign busy   = (r_rem != '0);
    assign accept = start && !busy;
    assign cnt    = gbn_pkg::SEQ_BITS'(r_next - r_base);
    assign ack_off = gbn_pkg::SEQ_BITS'(i_item.ack_number - r_base);

    always_comb begin
        n_base     = r_base;
        n_next     = r_next;
        n_wsize    = i_cfg_we ? i_cfg_data : r_wsize;
        n_rem      = r_rem;
        n_rseq     = r_rseq;
        n_strobe   = 1'b0;
        n_from_mem = 1'b0;
        n_out      = r_out;
        mem_req    = '0;

        n_out.seq_num     = '0;
        n_out.packet_data = '0;
        n_out.timer_cmd   = gbn_pkg::TMR_NONE;
        n_out.last        = 1'b1;

        if (busy) begin
            // resend walk
            mem_req.re        = 1'b1;
            mem_req.raddr     = r_rseq;
            n_strobe          = 1'b1;
            n_from_mem        = 1'b1;
            n_out.result_kind = gbn_pkg::RK_RESENT;
            n_out.seq_num     = r_rseq;
            n_out.last        = (r_rem == gbn_pkg::SEQ_BITS'(1));
            n_rem             = gbn_pkg::SEQ_BITS'(r_rem - 1'b1);
            n_rseq            = gbn_pkg::SEQ_BITS'(r_rseq + 1'b1);
        end else if (accept) begin
            case (i_item.kind)
                gbn_pkg::KIND_SEND: begin
                    n_strobe = 1'b1;
                    if (cnt >= r_wsize) begin
                        n_out.result_kind = gbn_pkg::RK_REFUSED;
                    end else begin
                        mem_req.we        = 1'b1;
                        mem_req.waddr     = r_next;
                        mem_req.wdata     = i_item.payload;
                        n_out.result_kind = gbn_pkg::RK_SENT;
                        n_out.seq_num     = r_next;
                        n_out.packet_data = i_item.payload;
                        n_out.timer_cmd   = (cnt == '0) ? gbn_pkg::TMR_START
                                                        : gbn_pkg::TMR_NONE;
                        n_next            = gbn_pkg::SEQ_BITS'(r_next + 1'b1);
                    end
                end
                gbn_pkg::KIND_ACK: begin
                    n_strobe = 1'b1;
                    if (i_item.ack_checksum_ok && (ack_off < cnt)) begin
                        n_base            = gbn_pkg::SEQ_BITS'(i_item.ack_number + 1'b1);
                        n_out.result_kind = gbn_pkg::RK_ACK_OK;
                        n_out.timer_cmd   = (r_next != n_base) ? gbn_pkg::TMR_RESTART
                                                               : gbn_pkg::TMR_STOP;
                    end else begin
                        n_out.result_kind = gbn_pkg::RK_ACK_IGNORE;
                    end
                end
                gbn_pkg::KIND_TIMEOUT: begin
                    n_strobe        = 1'b1;
                    n_out.timer_cmd = gbn_pkg::TMR_RESTART;
                    if (cnt == '0) begin
                        n_out.result_kind = gbn_pkg::RK_NO_RESEND;
                    end else begin
                        mem_req.re        = 1'b1;
                        mem_req.raddr     = r_base;
                        n_from_mem        = 1'b1;
                        n_out.result_kind = gbn_pkg::RK_RESENT;
                        n_out.seq_num     = r_base;
                        n_out.last        = (cnt == gbn_pkg::SEQ_BITS'(1));
                        n_rem             = gbn_pkg::SEQ_BITS'(cnt - 1'b1);
                        n_rseq            = gbn_pkg::SEQ_BITS'(r_base + 1'b1);
                    end
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end

        cnt_after         = gbn_pkg::SEQ_BITS'(n_next - n_base);
        n_out.base_after  = n_base;
        n_out.window_full = (cnt_after == r_wsize);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_next     <= '0;
            r_wsize    <= gbn_pkg::WSIZE_RESET;
            r_rem      <= '0;
            r_rseq     <= '0;
            r_strobe   <= 1'b0;
            r_from_mem <= 1'b0;
        end else begin
            r_base     <= n_base;
            r_next     <= n_next;
            r_wsize    <= n_wsize;
            r_rem      <= n_rem;
            r_rseq     <= n_rseq;
            r_strobe   <= n_strobe;
            r_from_mem <= n_from_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_mem_req  = mem_req;
    assign o_strobe   = r_strobe;
    assign o_from_mem = r_from_mem;
    assign o_meta     = r_out;

    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> r_strobe)
        else $error("resend step without result");

    a_resend_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.result_kind == gbn_pkg::RK_RESENT && !r_out.last)
        |=> (r_strobe && r_out.result_kind == gbn_pkg::RK_RESENT))
        else $error("resend run broken");

    a_mem_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_from_mem) |-> (r_out.result_kind == gbn_pkg::RK_RESENT))
        else $error("store data on non-resend item");

    a_window_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> ($stable(r_base) && $stable(r_next)))
        else $error("window moved during resend");

endmodule

/* hdl/go_back_n_sender_window.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-Back-N ARQ sender window, sequence numbers modulo 8, packet buffer in RAM.
// The first result is registered and is on the ports in the cycle after an item is taken.
// Throughput: one send or ack per cycle while not busy; a timeout with n packets
// outstanding gives n results on consecutive cycles, paced by the single read
// port of the packet buffer, with busy high until the last read. Results cannot be stalled.
// Reset: base and next sequence cleared, window size 4, buffer left as is.
// ----------------------------------------------------------------------------
module go_back_n_sender_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gbn_pkg::t_item_in  i_item,
    input  logic               i_cfg_we,
    input  gbn_pkg::t_wsize    i_cfg_data,
    output logic               o_strobe,
    output gbn_pkg::t_item_out o_result
);

    gbn_pkg::t_mem_req  mem_req;
    gbn_pkg::t_payload  mem_rdata;
    gbn_pkg::t_item_out meta;
    logic               from_mem;

    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_mem_req  (mem_req),
        .o_strobe   (o_strobe),
        .o_from_mem (from_mem),
        .o_meta     (meta)
    );

    gbn_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        o_result = meta;
        if (from_mem) begin
            o_result.packet_data = mem_rdata;
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Go-Back-N sender window. Items are pushed
// through the start/busy handshake with random gaps, and a behavioral copy of
// the window (base, next sequence, packet buffer, window size) predicts every
// result. Each strobed result is checked field by field against the oldest
// prediction. Directed tests cover the empty window, refusal, checksum and
// range filtering of acks, zero and shrunk windows; random phases sweep the
// window size with mostly well-formed send/ack traffic plus timeouts and noise.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    gbn_pkg::t_item_in  i_item;
    logic               i_cfg_we;
    gbn_pkg::t_wsize    i_cfg_data;
    logic               o_strobe;
    gbn_pkg::t_item_out o_result;

    go_back_n_sender_window DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // window copy
    gbn_pkg::t_seq      win_base;
    gbn_pkg::t_seq      next_seq;
    gbn_pkg::t_wsize    win_size;
    gbn_pkg::t_payload  pkt_buf [gbn_pkg::SEQ_SPACE];
    gbn_pkg::t_item_out pending_results [$];

    int                 err_count;
    int                 cycles;
    int                 item_count;
    bit                 start_held;
    bit                 gaps_on;
    gbn_pkg::t_item_out want;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic gbn_pkg::t_seq in_flight();
        return gbn_pkg::t_seq'(next_seq - win_base);
    endfunction

    function automatic void push_result(gbn_pkg::t_res_kind rk, gbn_pkg::t_seq seq,
                                        gbn_pkg::t_payload data,
                                        gbn_pkg::t_timer_cmd tcmd, logic lst);
        gbn_pkg::t_item_out r;
        r.result_kind = rk;
        r.seq_num     = seq;
        r.packet_data = data;
        r.timer_cmd   = tcmd;
        r.base_after  = win_base;
        r.window_full = (in_flight() == win_size);
        r.last        = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void sender_window_step(gbn_pkg::t_item_in it);
        gbn_pkg::t_seq cnt;
        gbn_pkg::t_seq off;
        gbn_pkg::t_seq seq;
        cnt = in_flight();
        case (it.kind)
            gbn_pkg::KIND_SEND: begin
                if (cnt >= win_size) begin
                    push_result(gbn_pkg::RK_REFUSED, '0, '0, gbn_pkg::TMR_NONE, 1'b1);
                end else begin
                    seq = next_seq;
                    pkt_buf[seq] = it.payload;
                    next_seq = gbn_pkg::t_seq'(next_seq + 1);
                    push_result(gbn_pkg::RK_SENT, seq, it.payload,
                                (cnt == 0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE,
                                1'b1);
                end
            end
            gbn_pkg::KIND_ACK: begin
                off = gbn_pkg::t_seq'(it.ack_number - win_base);
                if (it.ack_checksum_ok && off < cnt) begin
                    win_base = gbn_pkg::t_seq'(it.ack_number + 1);
                    push_result(gbn_pkg::RK_ACK_OK, '0, '0,
                                (in_flight() != 0) ? gbn_pkg::TMR_RESTART
                                                   : gbn_pkg::TMR_STOP, 1'b1);
                end else begin
                    push_result(gbn_pkg::RK_ACK_IGNORE, '0, '0, gbn_pkg::TMR_NONE, 1'b1);
                end
            end
            gbn_pkg::KIND_TIMEOUT: begin
                if (cnt == 0) begin
                    push_result(gbn_pkg::RK_NO_RESEND, '0, '0, gbn_pkg::TMR_RESTART, 1'b1);
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        seq = gbn_pkg::t_seq'(win_base + i);
                        push_result(gbn_pkg::RK_RESENT, seq, pkt_buf[seq],
                                    (i == 0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE,
                                    i == cnt - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(gbn_pkg::t_item_in it);
        int gap;
        start  <= 1'b1;
        i_item <= it;
        start_held = 1'b1;
        do @(posedge i_clk); while (busy);
        sender_window_step(it);
        item_count++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            start_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (start_held) begin
            start <= 1'b0;
            start_held = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(gbn_pkg::t_wsize w);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_size = w;
    endtask

    function automatic gbn_pkg::t_item_in make_item(gbn_pkg::t_in_kind k,
                                                    gbn_pkg::t_payload p,
                                                    gbn_pkg::t_seq a, logic ok);
        gbn_pkg::t_item_in it;
        it.kind            = k;
        it.payload         = p;
        it.ack_number      = a;
        it.ack_checksum_ok = ok;
        return it;
    endfunction

    function automatic gbn_pkg::t_payload rand_payload();
        return {$urandom, $urandom};
    endfunction

    task automatic test_empty_window();
        send_item(make_item(gbn_pkg::KIND_TIMEOUT, rand_payload(), 3'd5, 1'b1));
        send_item(make_item(gbn_pkg::KIND_ACK, '0, 3'd0, 1'b1));
        send_item(make_item(gbn_pkg::KIND_UNUSED, '1, 3'd7, 1'b1));
    endtask

    task automatic test_fill_and_refuse();
        send_item(make_item(gbn_pkg::KIND_SEND, '0, 3'd0, 1'b0));
        send_item(make_item(gbn_pkg::KIND_SEND, '1, 3'd7, 1'b1));
        send_item(make_item(gbn_pkg::KIND_SEND, {32{2'b10}}, 3'd2, 1'b0));
        send_item(make_item(gbn_pkg::KIND_SEND, {32{2'b01}}, 3'd5, 1'b1));
        send_item(make_item(gbn_pkg::KIND_SEND, rand_payload(), 3'd0, 1'b0));
        send_item(make_item(gbn_pkg::KIND_TIMEOUT, '0, 3'd0, 1'b0));
        send_item(make_item(gbn_pkg::KIND_ACK, '0, 3'd1, 1'b0));
        send_item(make_item(gbn_pkg::KIND_ACK, '0, 3'd5, 1'b1));
        send_item(make_item(gbn_pkg::KIND_ACK, '1, 3'd1, 1'b1));
        send_item(make_item(gbn_pkg::KIND_ACK, '0, 3'd3, 1'b1));
    endtask

    task automatic test_window_zero();
        write_window(3'd0);
        send_item(make_item(gbn_pkg::KIND_SEND, rand_payload(), 3'd0, 1'b1));
        send_item(make_item(gbn_pkg::KIND_TIMEOUT, '0, 3'd0, 1'b0));
    endtask

    task automatic test_shrunk_window();
        write_window(3'd7);
        repeat (7) send_item(make_item(gbn_pkg::KIND_SEND, rand_payload(), 3'd0, 1'b0));
        write_window(3'd2);
        send_item(make_item(gbn_pkg::KIND_SEND, rand_payload(), 3'd0, 1'b0));
        send_item(make_item(gbn_pkg::KIND_ACK, '0, gbn_pkg::t_seq'(win_base + 4), 1'b1));
        send_item(make_item(gbn_pkg::KIND_SEND, rand_payload(), 3'd0, 1'b0));
        send_item(make_item(gbn_pkg::KIND_ACK, '0, win_base, 1'b1));
        send_item(make_item(gbn_pkg::KIND_SEND, rand_payload(), 3'd0, 1'b0));
    endtask

    task automatic test_random_traffic(gbn_pkg::t_wsize w, int n_items);
        int                stop_at;
        int                r;
        gbn_pkg::t_seq     cnt;
        gbn_pkg::t_item_in it;
        write_window(w);
        gaps_on = $urandom_range(0, 3) != 0;
        stop_at = item_count + n_items;
        while (item_count < stop_at) begin
            cnt = in_flight();
            r = $urandom_range(0, 99);
            it = make_item(gbn_pkg::KIND_SEND, rand_payload(), gbn_pkg::t_seq'($urandom),
                           1'($urandom));
            if (r < 45) begin
                it.kind = gbn_pkg::KIND_SEND;
            end else if (r < 82) begin
                it.kind = gbn_pkg::KIND_ACK;
                if (cnt != 0 && $urandom_range(0, 9) < 8) begin
                    it.ack_number = gbn_pkg::t_seq'(win_base + $urandom_range(0, cnt - 1));
                    it.ack_checksum_ok = $urandom_range(0, 15) != 0;
                end
            end else if (r < 94) begin
                it.kind = gbn_pkg::KIND_TIMEOUT;
            end else begin
                it.kind = gbn_pkg::KIND_UNUSED;
            end
            send_item(it);
            if ($urandom_range(0, 39) == 0) drain();
            if ($urandom_range(0, 29) == 0) gaps_on = !gaps_on;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.result_kind !== want.result_kind) begin
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             want.result_kind, o_result.result_kind);
                    err_count++;
                end
                if (o_result.seq_num !== want.seq_num) begin
                    $display("%0t: seq_num expected %0d actual %0d", $time,
                             want.seq_num, o_result.seq_num);
                    err_count++;
                end
                if (o_result.packet_data !== want.packet_data) begin
                    $display("%0t: packet_data expected %h actual %h", $time,
                             want.packet_data, o_result.packet_data);
                    err_count++;
                end
                if (o_result.timer_cmd !== want.timer_cmd) begin
                    $display("%0t: timer_cmd expected %0d actual %0d", $time,
                             want.timer_cmd, o_result.timer_cmd);
                    err_count++;
                end
                if (o_result.base_after !== want.base_after) begin
                    $display("%0t: base_after expected %0d actual %0d", $time,
                             want.base_after, o_result.base_after);
                    err_count++;
                end
                if (o_result.window_full !== want.window_full) begin
                    $display("%0t: window_full expected %0b actual %0b", $time,
                             want.window_full, o_result.window_full);
                    err_count++;
                end
                if (o_result.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, o_result.last);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        err_count  = 0;
        item_count = 0;
        start_held = 1'b0;
        gaps_on    = 1'b1;
        win_base   = '0;
        next_seq   = '0;
        win_size   = gbn_pkg::WSIZE_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_window();
        test_fill_and_refuse();
        test_window_zero();
        test_shrunk_window();
        test_random_traffic(3'd7, 80);
        test_random_traffic(3'd1, 50);
        test_random_traffic(3'd5, 70);
        test_random_traffic(3'd0, 12);
        test_random_traffic(3'd3, 60);
        test_random_traffic(3'd6, 60);
        test_random_traffic(3'd2, 50);
        test_random_traffic(3'd4, 25);

        drain();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
hdl/gbn_pkg.sv
hdl/gbn_store.sv
hdl/gbn_ctrl.sv
hdl/go_back_n_sender_window.sv
verif/tb_top.sv
